@@ src/lprs_pkg.sv @@
// ----------------------------------------------------------------------------
// lprs_pkg
// Shared types, constants and register indexes of the route select block.
// ----------------------------------------------------------------------------
package lprs_pkg;

    // IPv6 compare width; IPv4 always compares 32 bits
    localparam int unsigned ADDR_BITS  = 128;
    localparam int unsigned V4_BITS    = 32;
    localparam int unsigned FULL_BITS  = 128;

    localparam logic [7:0]  NO_MATCH_LEN = 8'hFF;
    localparam logic [31:0] COST_MAX     = 32'hFFFF_FFFF;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_HI    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_LO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_PREFIX_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FAMILY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IFACE_ID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PROTOCOL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_METRIC      = 3'd6;

    typedef struct packed {
        logic [63:0] dest_addr_hi;
        logic [63:0] dest_addr_lo;
        logic [7:0]  dest_prefix_len;
        logic        dest_family;
        logic [63:0] own_iface_id;
        logic [7:0]  own_protocol;
        logic [31:0] own_metric;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  prefix_len;
        logic [63:0] iface_id;
        logic [7:0]  protocol;
        logic [31:0] metric;
        logic [31:0] iface_metric;
        logic        iface_metric_valid;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic        last;
    } row_t;

    typedef struct packed {
        logic [7:0]  len;
        logic [31:0] cost;
        logic [63:0] iface;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
    } best_t;

    localparam best_t BEST_CLEAR = '{
        len:    NO_MATCH_LEN,
        cost:   COST_MAX,
        iface:  64'd0,
        hop_hi: 64'd0,
        hop_lo: 64'd0
    };

endpackage

@@ src/longest_prefix_route_select_unit.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_select_unit
// Longest-prefix route selection over a stream of routing-table rows.
// ----------------------------------------------------------------------------
// Usage: program the destination prefix and own-route markers on the cfg
// channel (index/data, always ready) while no scan is in flight. Then stream
// the routing table, one row per transfer on the in channel, with last_row
// set on the final row. Each row is registered, checked against the
// destination and folded into the running best route.
// The last row produces one result transfer on the out channel: chosen
// interface, next hop and a changed flag against the route applied before;
// the result becomes the applied route and the search restarts.
// Throughput: one row per cycle unless in_ready drops, set by the single row
// register feeding the compare/add/select logic. The result is registered
// in the output register when the last row leaves the row register.
// A result waits in the output register while the receiver stalls; rows
// keep flowing until a second last row meets a full output register, then
// in_ready drops until the result is taken.
// Reset clears the configuration and the applied route to zero, and the
// search to no match, with both channels empty.
// ----------------------------------------------------------------------------
module longest_prefix_route_select_unit
    import lprs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           row_family,
    input  logic [63:0]          row_prefix_hi,
    input  logic [63:0]          row_prefix_lo,
    input  logic [7:0]           row_prefix_len,
    input  logic [63:0]          row_iface_id,
    input  logic [7:0]           row_protocol,
    input  logic [31:0]          row_metric,
    input  logic [31:0]          iface_metric,
    input  logic                 iface_metric_valid,
    input  logic [63:0]          hop_hi,
    input  logic [63:0]          hop_lo,
    input  logic                 last_row,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          chosen_iface,
    output logic [63:0]          chosen_hop_hi,
    output logic [63:0]          chosen_hop_lo,
    output logic                 route_changed
);

    cfg_t  cfg;
    row_t  row_reg;
    logic  row_valid_reg;
    best_t best_reg;
    best_t best_next;
    best_t chosen_reg;
    logic  changed_reg;
    logic  out_valid_reg;
    logic [63:0] applied_iface_reg;
    logic [63:0] applied_hop_hi_reg;
    logic [63:0] applied_hop_lo_reg;
    logic  row_go;
    logic  emit;
    logic  in_xfer;

    assign cfg_ready = 1'b1;

    lprs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lprs_row_eval u_row_eval (
        .cfg       (cfg),
        .row       (row_reg),
        .best      (best_reg),
        .best_next (best_next)
    );

    // a last row moves on only when the output register is free or draining
    assign row_go   = row_valid_reg && (!row_reg.last || !out_valid_reg || out_ready);
    assign emit     = row_go && row_reg.last;
    assign in_ready = !row_valid_reg || row_go;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            row_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            row_reg.family             <= row_family;
            row_reg.prefix_hi          <= row_prefix_hi;
            row_reg.prefix_lo          <= row_prefix_lo;
            row_reg.prefix_len         <= row_prefix_len;
            row_reg.iface_id           <= row_iface_id;
            row_reg.protocol           <= row_protocol;
            row_reg.metric             <= row_metric;
            row_reg.iface_metric       <= iface_metric;
            row_reg.iface_metric_valid <= iface_metric_valid;
            row_reg.hop_hi             <= hop_hi;
            row_reg.hop_lo             <= hop_lo;
            row_reg.last               <= last_row;
        end
    end

    // running best route and the route applied last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg           <= BEST_CLEAR;
            applied_iface_reg  <= 64'd0;
            applied_hop_hi_reg <= 64'd0;
            applied_hop_lo_reg <= 64'd0;
        end
        else if (row_go)
        begin
            if (row_reg.last)
            begin
                best_reg           <= BEST_CLEAR;
                applied_iface_reg  <= best_next.iface;
                applied_hop_hi_reg <= best_next.hop_hi;
                applied_hop_lo_reg <= best_next.hop_lo;
            end
            else
            begin
                best_reg <= best_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            chosen_reg  <= best_next;
            changed_reg <= (best_next.iface != applied_iface_reg)
                        || (best_next.hop_hi != applied_hop_hi_reg)
                        || (best_next.hop_lo != applied_hop_lo_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_iface  = chosen_reg.iface;
    assign chosen_hop_hi = chosen_reg.hop_hi;
    assign chosen_hop_lo = chosen_reg.hop_lo;
    assign route_changed = changed_reg;

    // search restarts after every result
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (best_reg.len == NO_MATCH_LEN))
        else $error("search state not cleared after result");

    // the emitted route becomes the applied route
    a_applied_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid && (applied_iface_reg == chosen_iface)
                  && (applied_hop_hi_reg == chosen_hop_hi)
                  && (applied_hop_lo_reg == chosen_hop_lo)))
        else $error("applied route differs from emitted result");

    // only a last row blocked by a full output may stall the input
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (row_valid_reg && row_reg.last && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

endmodule

@@ src/lprs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lprs_cfg_regs
// Configuration register file, written through an indexed write channel.
// ----------------------------------------------------------------------------
module lprs_cfg_regs
    import lprs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [63:0]          wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DEST_ADDR_HI:    cfg_next.dest_addr_hi    = wr_data;
                REG_DEST_ADDR_LO:    cfg_next.dest_addr_lo    = wr_data;
                REG_DEST_PREFIX_LEN: cfg_next.dest_prefix_len = wr_data[7:0];
                REG_DEST_FAMILY:     cfg_next.dest_family     = wr_data[0];
                REG_OWN_IFACE_ID:    cfg_next.own_iface_id    = wr_data;
                REG_OWN_PROTOCOL:    cfg_next.own_protocol    = wr_data[7:0];
                REG_OWN_METRIC:      cfg_next.own_metric      = wr_data[31:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/lprs_row_eval.sv @@
// ----------------------------------------------------------------------------
// lprs_row_eval
// Candidate check of one routing row and the best route after that row.
// ----------------------------------------------------------------------------
module lprs_row_eval
    import lprs_pkg::*;
(
    input  cfg_t  cfg,
    input  row_t  row,
    input  best_t best,
    output best_t best_next
);

    logic [7:0]           width_lim;
    logic                 have;
    logic [FULL_BITS-1:0] diff;
    logic [FULL_BITS-1:0] mask;
    logic                 prefix_eq;
    logic [32:0]          cost_sum;
    logic [31:0]          cost;
    logic                 ok;
    logic                 take;

    assign width_lim = cfg.dest_family ? 8'(ADDR_BITS) : 8'(V4_BITS);
    assign have      = (best.len != NO_MATCH_LEN);

    // leading prefix bits, counted from the msb of the hi word
    assign diff = {row.prefix_hi ^ cfg.dest_addr_hi, row.prefix_lo ^ cfg.dest_addr_lo};

    always_comb
    begin
        for (int j = 0; j < FULL_BITS; j++)
        begin
            mask[FULL_BITS-1-j] = (9'(j) < {1'b0, row.prefix_len});
        end
    end

    assign prefix_eq = ((diff & mask) == '0);

    assign cost_sum = {1'b0, row.metric} + {1'b0, row.iface_metric};
    assign cost     = cost_sum[32] ? COST_MAX : cost_sum[31:0];

    assign ok = (row.iface_id != cfg.own_iface_id)
             && !(have && (row.prefix_len < best.len))
             && !((row.protocol == cfg.own_protocol) && (row.metric == cfg.own_metric))
             && (row.family == {1'b0, cfg.dest_family})
             && (row.prefix_len <= cfg.dest_prefix_len)
             && (row.prefix_len <= width_lim)
             && prefix_eq
             && row.iface_metric_valid;

    // equal length keeps the earlier row unless strictly cheaper
    assign take = ok && !(have && (row.prefix_len == best.len) && (cost >= best.cost));

    always_comb
    begin
        best_next = best;
        if (take)
        begin
            best_next.len    = row.prefix_len;
            best_next.cost   = cost;
            best_next.hop_hi = row.hop_hi;
            best_next.hop_lo = row.hop_lo;
            best_next.iface  = (row.prefix_len == cfg.dest_prefix_len) ? 64'd0 : row.iface_id;
        end
    end

endmodule

@@ verif/longest_prefix_route_select_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_select_unit_tb
// Streams routing-table scans into the route select unit under a series of
// destination settings and checks every chosen route, next hop and changed
// flag against a local longest-prefix predictor, with random gaps on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module longest_prefix_route_select_unit_tb;
    import lprs_pkg::*;

    localparam logic [1:0] FAM_V4    = 2'd0;
    localparam logic [1:0] FAM_V6    = 2'd1;
    localparam logic [1:0] FAM_OTHER = 2'd2;
    localparam logic [1:0] FAM_RSVD  = 2'd3;

    // index past the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [63:0] DIRECT_DEST = 64'h0A01_0200_0000_0000;

    typedef struct packed {
        logic [63:0] iface;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic        changed;
    } route_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    row_t                 row_drv;
    logic                 out_valid;
    logic                 out_ready;
    logic [63:0]          chosen_iface;
    logic [63:0]          chosen_hop_hi;
    logic [63:0]          chosen_hop_lo;
    logic                 route_changed;

    // predictor state
    cfg_t        cfg_now;
    best_t       search;
    logic [63:0] applied_iface;
    logic [63:0] applied_hop_hi;
    logic [63:0] applied_hop_lo;
    route_t      route_q[$];

    int unsigned mismatches;
    bit          src_idle;
    bit          sink_idle;
    int unsigned sink_hold;

    longest_prefix_route_select_unit uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .row_family         (row_drv.family),
        .row_prefix_hi      (row_drv.prefix_hi),
        .row_prefix_lo      (row_drv.prefix_lo),
        .row_prefix_len     (row_drv.prefix_len),
        .row_iface_id       (row_drv.iface_id),
        .row_protocol       (row_drv.protocol),
        .row_metric         (row_drv.metric),
        .iface_metric       (row_drv.iface_metric),
        .iface_metric_valid (row_drv.iface_metric_valid),
        .hop_hi             (row_drv.hop_hi),
        .hop_lo             (row_drv.hop_lo),
        .last_row           (row_drv.last),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .chosen_iface       (chosen_iface),
        .chosen_hop_hi      (chosen_hop_hi),
        .chosen_hop_lo      (chosen_hop_lo),
        .route_changed      (route_changed)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // fold one accepted row into the running best route, emit on the last row
    task automatic fold_row(input row_t r);
        logic [127:0] mask;
        logic [32:0]  sum;
        logic [31:0]  cost;
        int unsigned  span;
        bit           have;
        bit           ok;
        route_t       res;
        span = cfg_now.dest_family ? ADDR_BITS : V4_BITS;
        have = search.len != NO_MATCH_LEN;
        ok = r.iface_id != cfg_now.own_iface_id
            && !(have && r.prefix_len < search.len)
            && !(r.protocol == cfg_now.own_protocol && r.metric == cfg_now.own_metric)
            && r.family == {1'b0, cfg_now.dest_family}
            && r.prefix_len <= cfg_now.dest_prefix_len
            && r.prefix_len <= span
            && r.iface_metric_valid;
        mask = ~({128{1'b1}} >> r.prefix_len);
        if ((({r.prefix_hi, r.prefix_lo}
              ^ {cfg_now.dest_addr_hi, cfg_now.dest_addr_lo}) & mask) != '0)
            ok = 1'b0;
        if (ok)
        begin
            sum  = {1'b0, r.metric} + {1'b0, r.iface_metric};
            cost = sum[32] ? COST_MAX : sum[31:0];
            if (!(have && r.prefix_len == search.len && cost >= search.cost))
            begin
                search.len    = r.prefix_len;
                search.cost   = cost;
                search.hop_hi = r.hop_hi;
                search.hop_lo = r.hop_lo;
                search.iface  = (r.prefix_len == cfg_now.dest_prefix_len) ? 64'd0
                                                                          : r.iface_id;
            end
        end
        if (r.last)
        begin
            res.iface   = search.iface;
            res.hop_hi  = search.hop_hi;
            res.hop_lo  = search.hop_lo;
            res.changed = search.iface != applied_iface || search.hop_hi != applied_hop_hi
                          || search.hop_lo != applied_hop_lo;
            route_q.push_back(res);
            applied_iface  = search.iface;
            applied_hop_hi = search.hop_hi;
            applied_hop_lo = search.hop_lo;
            search         = BEST_CLEAR;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DEST_ADDR_HI:    cfg_now.dest_addr_hi    = data;
            REG_DEST_ADDR_LO:    cfg_now.dest_addr_lo    = data;
            REG_DEST_PREFIX_LEN: cfg_now.dest_prefix_len = data[7:0];
            REG_DEST_FAMILY:     cfg_now.dest_family     = data[0];
            REG_OWN_IFACE_ID:    cfg_now.own_iface_id    = data;
            REG_OWN_PROTOCOL:    cfg_now.own_protocol    = data[7:0];
            REG_OWN_METRIC:      cfg_now.own_metric      = data[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_route(input cfg_t c);
        write_reg(REG_DEST_ADDR_HI, c.dest_addr_hi);
        write_reg(REG_DEST_ADDR_LO, c.dest_addr_lo);
        write_reg(REG_DEST_PREFIX_LEN, {56'd0, c.dest_prefix_len});
        write_reg(REG_DEST_FAMILY, {63'd0, c.dest_family});
        write_reg(REG_OWN_IFACE_ID, c.own_iface_id);
        write_reg(REG_OWN_PROTOCOL, {56'd0, c.own_protocol});
        write_reg(REG_OWN_METRIC, {32'd0, c.own_metric});
        write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    task automatic send_row(input row_t r);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_drv  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        fold_row(r);
    endtask

    // let every scan finish and the last row settle before touching registers
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (route_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic row_t route_row(input logic [1:0] fam, input logic [63:0] hi,
                                       input logic [7:0] len, input logic [63:0] iface,
                                       input logic [7:0] proto, input logic [31:0] met,
                                       input logic [31:0] imet, input logic ivalid,
                                       input logic [63:0] hop, input logic last);
        row_t r;
        r.family             = fam;
        r.prefix_hi          = hi;
        r.prefix_lo          = 64'd0;
        r.prefix_len         = len;
        r.iface_id           = iface;
        r.protocol           = proto;
        r.metric             = met;
        r.iface_metric       = imet;
        r.iface_metric_valid = ivalid;
        r.hop_hi             = hop;
        r.hop_lo             = ~hop;
        r.last               = last;
        return r;
    endfunction

    // fit rows target the current destination; the rest is noise
    function automatic row_t random_row(input bit fit, input bit last);
        row_t         r;
        logic [127:0] addr;
        logic [127:0] mask;
        int unsigned  span;
        int unsigned  len;
        r.prefix_hi          = {$urandom, $urandom};
        r.prefix_lo          = {$urandom, $urandom};
        r.iface_id           = {$urandom, $urandom};
        r.protocol           = 8'($urandom_range(0, 255));
        r.metric             = $urandom;
        r.iface_metric       = $urandom;
        r.iface_metric_valid = 1'($urandom_range(0, 1));
        r.hop_hi             = {$urandom, $urandom};
        r.hop_lo             = {$urandom, $urandom};
        r.family             = 2'($urandom_range(0, 3));
        r.prefix_len         = 8'($urandom_range(0, 255));
        if (fit)
        begin
            span = cfg_now.dest_family ? ADDR_BITS : V4_BITS;
            if (cfg_now.dest_prefix_len < span)
                span = cfg_now.dest_prefix_len;
            case ($urandom_range(0, 3))
                0:       len = span;
                1:       len = (span == 0) ? 0 : span - 1;
                2:       len = span / 2;
                default: len = $urandom_range(0, span);
            endcase
            mask = ~({128{1'b1}} >> len);
            addr = ({cfg_now.dest_addr_hi, cfg_now.dest_addr_lo} & mask)
                   | ({r.prefix_hi, r.prefix_lo} & ~mask);
            if (len > 0 && $urandom_range(0, 7) == 0)
                addr ^= 128'd1 << (128 - $urandom_range(1, len));
            {r.prefix_hi, r.prefix_lo} = addr;
            r.prefix_len         = 8'(len);
            r.family             = {1'b0, cfg_now.dest_family};
            r.iface_id           = ($urandom_range(0, 9) == 0) ? cfg_now.own_iface_id
                                                                : 64'($urandom_range(1, 6));
            r.protocol           = ($urandom_range(0, 3) == 0) ? cfg_now.own_protocol
                                                                : r.protocol;
            r.metric             = ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 20);
            r.iface_metric       = ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
            begin
                r.protocol = cfg_now.own_protocol;
                r.metric   = cfg_now.own_metric;
            end
            r.iface_metric_valid = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 1) == 0)
                r.hop_hi = 64'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                r.hop_lo = 64'($urandom_range(0, 3));
        end
        r.last = last;
        return r;
    endfunction

    task automatic run_scans(input int unsigned rows, input int unsigned max_scan);
        row_t        scan_rows[$];
        row_t        prev_rows[$];
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < rows)
        begin
            // repeating a scan should report an unchanged route
            if (prev_rows.size() != 0 && $urandom_range(0, 3) == 0)
                scan_rows = prev_rows;
            else
            begin
                scan_rows.delete();
                n = $urandom_range(1, max_scan);
                for (int unsigned i = 0; i < n; i++)
                    scan_rows.push_back(random_row($urandom_range(0, 4) != 0, i == n - 1));
            end
            foreach (scan_rows[i])
                send_row(scan_rows[i]);
            sent += scan_rows.size();
            prev_rows = scan_rows;
        end
    endtask

    task automatic test_reset_settings();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        run_scans(60, 4);
        drain();
    endtask

    task automatic test_directed_ipv4();
        cfg_t c;
        c = '{dest_addr_hi: DIRECT_DEST, dest_addr_lo: 64'd0, dest_prefix_len: 8'd24,
              dest_family: 1'b0, own_iface_id: 64'h77, own_protocol: 8'd3, own_metric: 32'd5};
        program_route(c);
        send_row(route_row(FAM_OTHER, DIRECT_DEST, 8'd16, 64'd1, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h11, 1'b0));
        send_row(route_row(FAM_RSVD, DIRECT_DEST, 8'd16, 64'd1, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h12, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd16, 64'h77, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h13, 1'b0));
        // own route marker: protocol and metric both match
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd16, 64'd2, 8'd3, 32'd5, 32'd1, 1'b1,
                           64'h14, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd16, 64'd2, 8'd3, 32'd6, 32'd4, 1'b0,
                           64'h15, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd25, 64'd2, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h16, 1'b0));
        send_row(route_row(FAM_V4, 64'h0A00_0200_0000_0000, 8'd16, 64'd2, 8'd1, 32'd1,
                           32'd1, 1'b1, 64'h17, 1'b0));
        send_row(route_row(FAM_V4, {$urandom, $urandom}, 8'd0, 64'd3, 8'd1, 32'd10,
                           32'd10, 1'b1, 64'h30, 1'b0));
        // same protocol, other metric: still a candidate
        send_row(route_row(FAM_V4, DIRECT_DEST | 64'hFF_FFFF_FFFF, 8'd16, 64'd4, 8'd3,
                           32'd6, 32'd4, 1'b1, 64'h40, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd8, 64'd2, 8'd1, 32'd0, 32'd0, 1'b1,
                           64'h18, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd16, 64'd5, 8'd1, 32'd7, 32'd3, 1'b1,
                           64'h50, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd16, 64'd6, 8'd1, 32'd6, 32'd3, 1'b1,
                           64'h60, 1'b0));
        // saturating cost, then an equal all-ones cost that must lose
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd20, 64'd7, 8'd1, 32'hFFFF_FFF0,
                           32'h100, 1'b1, 64'h70, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd20, 64'd8, 8'd1, 32'hFFFF_FFFF,
                           32'd0, 1'b1, 64'h80, 1'b0));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd24, 64'd9, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h90, 1'b1));
        send_row(route_row(FAM_OTHER, DIRECT_DEST, 8'd24, 64'd9, 8'd1, 32'd1, 32'd1, 1'b1,
                           64'h91, 1'b1));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd24, 64'd9, 8'd1, 32'd1, 32'd1, 1'b0,
                           64'h92, 1'b1));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd23, 64'd10, 8'd1, 32'd2, 32'd2, 1'b1,
                           64'hA0, 1'b1));
        send_row(route_row(FAM_V4, DIRECT_DEST, 8'd23, 64'd10, 8'd1, 32'd2, 32'd2, 1'b1,
                           64'hA0, 1'b1));
        drain();
    endtask

    task automatic test_prefix_width();
        cfg_t c;
        c = '{dest_addr_hi: 64'hC0A8_0101_8000_0000, dest_addr_lo: {$urandom, $urandom},
              dest_prefix_len: 8'd40, dest_family: 1'b0, own_iface_id: 64'd0,
              own_protocol: 8'd0, own_metric: 32'd0};
        program_route(c);
        // ipv4 compares 32 bits at most, longer rows never count
        send_row(route_row(FAM_V4, 64'hC0A8_0101_8000_0000, 8'd33, 64'd12, 8'd1, 32'd1,
                           32'd1, 1'b1, 64'hB0, 1'b0));
        send_row(route_row(FAM_V4, 64'hC0A8_0101_8000_0000, 8'd32, 64'd11, 8'd1, 32'd1,
                           32'd1, 1'b1, 64'hB1, 1'b1));
        drain();
    endtask

    task automatic test_ipv6_extremes();
        cfg_t c;
        c = '{dest_addr_hi: '1, dest_addr_lo: '1, dest_prefix_len: 8'd128,
              dest_family: 1'b1, own_iface_id: '1, own_protocol: 8'hFF,
              own_metric: 32'hFFFF_FFFF};
        program_route(c);
        src_idle  = 1'b1;
        sink_idle = 1'b0;
        run_scans(150, 6);
        drain();
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int k = 0; k < 6; k++)
        begin
            c.dest_family     = 1'($urandom_range(0, 1));
            c.dest_addr_hi    = {$urandom, $urandom};
            c.dest_addr_lo    = {$urandom, $urandom};
            c.dest_prefix_len = c.dest_family ? 8'($urandom_range(0, 128))
                                              : 8'($urandom_range(0, 32));
            c.own_iface_id    = $urandom_range(0, 1) ? 64'($urandom_range(1, 6))
                                                     : {$urandom, $urandom};
            c.own_protocol    = 8'($urandom_range(0, 255));
            c.own_metric      = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom;
            program_route(c);
            src_idle  = (k % 3) != 1;
            sink_idle = (k % 3) != 2;
            run_scans(200, 8);
            drain();
        end
    endtask

    task automatic test_output_stall();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 300;
        run_scans(120, 3);
        drain();
    endtask

    // receiver: random stall per result, plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else
                stall = sink_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready) && sink_hold == 0);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : route_check
        route_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (route_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with none pending, expected nothing actual %h",
                         $time, chosen_iface);
            end
            else
            begin
                want = route_q.pop_front();
                check_field("chosen_iface", want.iface, chosen_iface);
                check_field("chosen_hop_hi", want.hop_hi, chosen_hop_hi);
                check_field("chosen_hop_lo", want.hop_lo, chosen_hop_lo);
                check_field("route_changed", {63'd0, want.changed}, {63'd0, route_changed});
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DEST_ADDR_HI;
        cfg_data       = 64'd0;
        in_valid       = 1'b0;
        row_drv        = '0;
        cfg_now        = '0;
        search         = BEST_CLEAR;
        applied_iface  = 64'd0;
        applied_hop_hi = 64'd0;
        applied_hop_lo = 64'd0;
        mismatches     = 0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        sink_hold      = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_directed_ipv4();
        test_prefix_width();
        test_ipv6_extremes();
        test_random_settings();
        test_output_stall();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && route_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
